// ===== hw/rtl/msce_pkg.sv =====
`default_nettype none

package msce_pkg;

  // Item geometry
  localparam int unsigned WordBytes    = 4;
  localparam int unsigned BytesPerItem = 4;
  localparam int unsigned CntW         = $clog2(BytesPerItem + 1);
  localparam int unsigned DataW        = 32;
  localparam int unsigned CountW       = 3;
  localparam int unsigned InTdataW     = 40;
  localparam int unsigned OutTdataW    = 32;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE = 1'b0,
    REG_SEED = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ALG_CRC8  = 3'd0,
    ALG_KOOP  = 3'd1,
    ALG_CRC16 = 3'd2,
    ALG_CCITT = 3'd3,
    ALG_CRC32 = 3'd4
  } algo_e;

  localparam logic [2:0]  ModeReset = ALG_CRC32;
  localparam logic [31:0] SeedReset = 32'hFFFF_FFFF;

  localparam logic [7:0]  Crc8Poly  = 8'h07;
  localparam logic [15:0] Crc16Poly = 16'hA001;
  localparam logic [15:0] CcittPoly = 16'h1021;
  localparam logic [31:0] Crc32Poly = 32'hEDB8_8320;
  localparam logic [31:0] Crc32Xor  = 32'hFFFF_FFFF;

  // CRC-8/KOOP byte table
  localparam logic [7:0] KoopRom [256] = '{
    8'hea, 8'hd4, 8'h96, 8'ha8, 8'h12, 8'h2c, 8'h6e, 8'h50,
    8'h7f, 8'h41, 8'h03, 8'h3d, 8'h87, 8'hb9, 8'hfb, 8'hc5,
    8'ha5, 8'h9b, 8'hd9, 8'he7, 8'h5d, 8'h63, 8'h21, 8'h1f,
    8'h30, 8'h0e, 8'h4c, 8'h72, 8'hc8, 8'hf6, 8'hb4, 8'h8a,
    8'h74, 8'h4a, 8'h08, 8'h36, 8'h8c, 8'hb2, 8'hf0, 8'hce,
    8'he1, 8'hdf, 8'h9d, 8'ha3, 8'h19, 8'h27, 8'h65, 8'h5b,
    8'h3b, 8'h05, 8'h47, 8'h79, 8'hc3, 8'hfd, 8'hbf, 8'h81,
    8'hae, 8'h90, 8'hd2, 8'hec, 8'h56, 8'h68, 8'h2a, 8'h14,
    8'hb3, 8'h8d, 8'hcf, 8'hf1, 8'h4b, 8'h75, 8'h37, 8'h09,
    8'h26, 8'h18, 8'h5a, 8'h64, 8'hde, 8'he0, 8'ha2, 8'h9c,
    8'hfc, 8'hc2, 8'h80, 8'hbe, 8'h04, 8'h3a, 8'h78, 8'h46,
    8'h69, 8'h57, 8'h15, 8'h2b, 8'h91, 8'haf, 8'hed, 8'hd3,
    8'h2d, 8'h13, 8'h51, 8'h6f, 8'hd5, 8'heb, 8'ha9, 8'h97,
    8'hb8, 8'h86, 8'hc4, 8'hfa, 8'h40, 8'h7e, 8'h3c, 8'h02,
    8'h62, 8'h5c, 8'h1e, 8'h20, 8'h9a, 8'ha4, 8'he6, 8'hd8,
    8'hf7, 8'hc9, 8'h8b, 8'hb5, 8'h0f, 8'h31, 8'h73, 8'h4d,
    8'h58, 8'h66, 8'h24, 8'h1a, 8'ha0, 8'h9e, 8'hdc, 8'he2,
    8'hcd, 8'hf3, 8'hb1, 8'h8f, 8'h35, 8'h0b, 8'h49, 8'h77,
    8'h17, 8'h29, 8'h6b, 8'h55, 8'hef, 8'hd1, 8'h93, 8'had,
    8'h82, 8'hbc, 8'hfe, 8'hc0, 8'h7a, 8'h44, 8'h06, 8'h38,
    8'hc6, 8'hf8, 8'hba, 8'h84, 8'h3e, 8'h00, 8'h42, 8'h7c,
    8'h53, 8'h6d, 8'h2f, 8'h11, 8'hab, 8'h95, 8'hd7, 8'he9,
    8'h89, 8'hb7, 8'hf5, 8'hcb, 8'h71, 8'h4f, 8'h0d, 8'h33,
    8'h1c, 8'h22, 8'h60, 8'h5e, 8'he4, 8'hda, 8'h98, 8'ha6,
    8'h01, 8'h3f, 8'h7d, 8'h43, 8'hf9, 8'hc7, 8'h85, 8'hbb,
    8'h94, 8'haa, 8'he8, 8'hd6, 8'h6c, 8'h52, 8'h10, 8'h2e,
    8'h4e, 8'h70, 8'h32, 8'h0c, 8'hb6, 8'h88, 8'hca, 8'hf4,
    8'hdb, 8'he5, 8'ha7, 8'h99, 8'h23, 8'h1d, 8'h5f, 8'h61,
    8'h9f, 8'ha1, 8'he3, 8'hdd, 8'h67, 8'h59, 8'h1b, 8'h25,
    8'h0a, 8'h34, 8'h76, 8'h48, 8'hf2, 8'hcc, 8'h8e, 8'hb0,
    8'hd0, 8'hee, 8'hac, 8'h92, 8'h28, 8'h16, 8'h54, 8'h6a,
    8'h45, 8'h7b, 8'h39, 8'h07, 8'hbd, 8'h83, 8'hc1, 8'hff
  };

  // Result of one item through the datapath
  typedef struct packed {
    logic [31:0] crc_raw;
    logic [31:0] crc_shown;
    logic        len_err;
  } step_res_t;

  // One message byte, bitwise forms (KOOP by table lookup)
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ Crc8Poly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] koop_byte(logic [7:0] crc, logic [7:0] b);
    return KoopRom[crc ^ b];
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc16Poly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] ccitt_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CcittPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc32Poly) : (c >> 1);
    end
    return c;
  endfunction

  // Byte k of the data word, zero past the word's end
  function automatic logic [7:0] byte_at(logic [DataW-1:0] data, int unsigned k);
    logic [DataW-1:0] sh;
    sh = '0;
    if (k < WordBytes) sh = data >> (8 * k);
    return sh[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msce_crc_step.sv =====
`default_nettype none

module msce_crc_step (
  input  logic [31:0]                crc_i,
  input  logic [2:0]                 mode_i,
  input  logic [31:0]                seed_i,
  input  logic [msce_pkg::DataW-1:0] data_i,
  input  logic [msce_pkg::CountW-1:0] count_i,
  input  logic                       first_i,
  input  logic                       last_i,
  output msce_pkg::step_res_t        res_o
);
  import msce_pkg::*;

  logic [31:0]     start;
  logic [CntW-1:0] cnt_sat;
  logic [7:0]      c8;
  logic [15:0]     c16;
  logic [31:0]     c32;
  logic            is_crc32;

  // Saturate the byte count for the byte-wise modes
  always_comb begin
    if (int'(count_i) > BytesPerItem) cnt_sat = CntW'(BytesPerItem);
    else                              cnt_sat = CntW'(count_i);
  end

  // Seed load, then the unrolled byte steps of the selected algorithm
  always_comb begin
    start    = first_i ? seed_i : crc_i;
    c8       = start[7:0];
    c16      = start[15:0];
    c32      = start;
    is_crc32 = 1'b0;
    res_o.crc_raw = '0;
    case (mode_i)
      ALG_CRC8: begin
        for (int k = 0; k < BytesPerItem; k++) begin
          if (k < int'(cnt_sat)) c8 = crc8_byte(c8, byte_at(data_i, k));
        end
        res_o.crc_raw = {24'h0, c8};
      end
      ALG_KOOP: begin
        for (int k = 0; k < BytesPerItem; k++) begin
          if (k < int'(cnt_sat)) c8 = koop_byte(c8, byte_at(data_i, k));
        end
        res_o.crc_raw = {24'h0, c8};
      end
      ALG_CRC16: begin
        for (int k = 0; k < BytesPerItem; k++) begin
          if (k < int'(cnt_sat)) c16 = crc16_byte(c16, byte_at(data_i, k));
        end
        res_o.crc_raw = {16'h0, c16};
      end
      ALG_CCITT: begin
        for (int k = 0; k < BytesPerItem; k++) begin
          if (k < int'(cnt_sat)) c16 = ccitt_byte(c16, byte_at(data_i, k));
        end
        res_o.crc_raw = {16'h0, c16};
      end
      default: begin
        // CRC-32 and unused codes: whole word, high byte first
        is_crc32 = 1'b1;
        for (int k = WordBytes - 1; k >= 0; k--) begin
          c32 = crc32_byte(c32, byte_at(data_i, k));
        end
        res_o.crc_raw = c32;
      end
    endcase
    res_o.len_err   = is_crc32 && (int'(count_i) < WordBytes);
    res_o.crc_shown = (is_crc32 && last_i) ? (res_o.crc_raw ^ Crc32Xor) : res_o.crc_raw;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_standard_crc_engine.sv =====
// Channel   Dir  Bits                        Contents
// s_axis    in   tdata 40, tuser 1, tlast    data word, byte count / first / last
// m_axis    out  tdata 32, tuser 1, tlast    crc value / length error / final
// cfg       in   we, idx 1, data 32          algorithm mode, seed
//
// One item per cycle sustained while m_axis_tready stays high; a result beat passes the
// input register and then the output register before it is presented.
// The running CRC feeds back from the result side of the input register, so the byte
// steps of one word (four unrolled steps) set the cycle time.
// Reset clears the running CRC to zero, mode to CRC-32 and seed to all ones.
// A stalled output holds its beat; the input register keeps taking beats until both
// stages are full.
`default_nettype none

module multi_standard_crc_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] data_word, [34:32] byte_count, [39:35] zero
  input  logic [msce_pkg::InTdataW-1:0]    s_axis_tdata,
  // [0] first_item
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] crc_value
  output logic [msce_pkg::OutTdataW-1:0]   m_axis_tdata,
  // [0] length_error
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [msce_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [msce_pkg::CfgDataW-1:0]    cfg_data_i
);
  import msce_pkg::*;

  logic [2:0]        mode_q;
  logic [31:0]       seed_q;
  logic [31:0]       crc_q, crc_d;

  logic              in_valid_q;
  logic [DataW-1:0]  in_data_q;
  logic [CountW-1:0] in_count_q;
  logic              in_first_q;
  logic              in_last_q;

  logic              out_valid_q;
  logic [31:0]       out_crc_q;
  logic              out_err_q;
  logic              out_last_q;

  logic              advance;
  logic              in_take;
  step_res_t         res;

  // Handshake: input stage moves on when the output register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
      seed_q <= SeedReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE: mode_q <= cfg_data_i[2:0];
        REG_SEED: seed_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q  <= s_axis_tdata[DataW-1:0];
      in_count_q <= s_axis_tdata[DataW +: CountW];
      in_first_q <= s_axis_tuser;
      in_last_q  <= s_axis_tlast;
    end
  end

  msce_crc_step u_step (
    .crc_i   (crc_q),
    .mode_i  (mode_q),
    .seed_i  (seed_q),
    .data_i  (in_data_q),
    .count_i (in_count_q),
    .first_i (in_first_q),
    .last_i  (in_last_q),
    .res_o   (res)
  );

  assign crc_d = res.crc_raw;

  // Running CRC, updated as the beat leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (advance) begin
      crc_q <= crc_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_crc_q  <= res.crc_shown;
      out_err_q  <= res.len_err;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/msce_checker.sv =====
`default_nettype none

module msce_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [msce_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import msce_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] inflight_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // No result without an accepted input
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 2'd0)
    else $error("result beat with nothing in flight");

  // Two stages hold at most two beats
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 2'd2)
    else $error("more beats in flight than stages");

  // Input is only held off when both stages are full
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q < 2'd2 |-> s_axis_tready)
    else $error("input stalled with a free stage");

endmodule

bind multi_standard_crc_engine msce_checker u_msce_checker (.*);

`default_nettype wire
